FILE: design/rhsm_pkg.sv
`timescale 1ns / 1ps

package rhsm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [IN_USER_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_TEXT    = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic clear;
        logic pat_shift;
        logic win_shift;
    } cell_ctrl_t;

    // What the compare stage hands to the output stage with each word.
    typedef struct packed {
        logic               is_text;
        logic               overflow;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   len;
    } stage_info_t;

endpackage

FILE: design/rhsm_cell.sv
`timescale 1ns / 1ps

module rhsm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rhsm_pkg::cell_ctrl_t      ctrl,
    input  logic [rhsm_pkg::BYTE_W-1:0] pat_in,
    input  logic [rhsm_pkg::BYTE_W-1:0] win_in,
    input  logic                      used_in,
    output logic [rhsm_pkg::BYTE_W-1:0] pat_out,
    output logic [rhsm_pkg::BYTE_W-1:0] win_out,
    output logic                      used_out,
    output logic                      eq_out
);

    logic [rhsm_pkg::BYTE_W-1:0] pat_reg;
    logic [rhsm_pkg::BYTE_W-1:0] win_reg;
    logic                        used_reg;
    logic                        eq_reg;
    logic                        eq_next;

    // An unused cell never blocks a match. The incoming window byte is the
    // value this cell holds after the shift.
    assign eq_next = !used_reg || (pat_reg == win_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.pat_shift)
        begin
            used_reg <= used_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pat_shift)
        begin
            pat_reg <= pat_in;
        end
        if (ctrl.win_shift)
        begin
            win_reg <= win_in;
            eq_reg  <= eq_next;
        end
    end

    assign pat_out  = pat_reg;
    assign win_out  = win_reg;
    assign used_out = used_reg;
    assign eq_out   = eq_reg;

endmodule

FILE: design/rhsm_match.sv
`timescale 1ns / 1ps

module rhsm_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rhsm_pkg::stage_info_t              info,
    input  logic [rhsm_pkg::MAX_PATTERN-1:0]   eq_bits,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rhsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic                              out_valid_reg;
    logic                              match_reg;
    logic [rhsm_pkg::COUNT_W-1:0]      start_reg;
    logic                              overflow_reg;
    logic                              match_next;
    logic [rhsm_pkg::COUNT_W-1:0]      count_len;

    assign count_len  = rhsm_pkg::COUNT_W'(info.len);
    assign match_next = info.is_text && (info.len != '0) && (info.count >= count_len)
                        && (&eq_bits);
    assign in_ready   = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            match_reg    <= match_next;
            start_reg    <= match_next ? (info.count - count_len) : '0;
            overflow_reg <= info.overflow;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rhsm_pkg::OUT_DATA_W - rhsm_pkg::COUNT_W - 2){1'b0}},
                            overflow_reg, start_reg, match_reg};

    property p_start_zero_without_match;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !match_reg) |-> (start_reg == '0);
    endproperty
    a_start_zero_without_match: assert property (p_start_zero_without_match)
        else $error("match_start nonzero without a match");

    property p_match_and_overflow_exclusive;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(match_reg && overflow_reg);
    endproperty
    a_match_and_overflow_exclusive: assert property (p_match_and_overflow_exclusive)
        else $error("match and overflow reported on one word");

    property p_load_sets_valid;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid_reg;
    endproperty
    a_load_sets_valid: assert property (p_load_sets_valid)
        else $error("accepted result lost in output stage");

endmodule

FILE: design/rolling_hash_string_matcher.sv
`timescale 1ns / 1ps

// Streaming single-pattern string matcher.
// Input words arrive on s_axis: tuser carries the action (clear all, append a
// pattern byte, text byte, restart the text while keeping the pattern) and
// tdata carries the byte. Every accepted word produces exactly one result
// word on m_axis: a match flag, the zero-based start index of the matched
// window in the text, and a flag for a pattern byte dropped because the
// pattern already holds 64 bytes.
// The pattern and the recent text live in a row of 64 cells, newest byte in
// cell 0, so each cell compares its own pattern byte with its own window byte.
// A match is decided by the exact byte compare over all used cells once the
// text holds at least a full window. The text counter saturates at 2^32-1.
// Throughput is one word per cycle while m_axis takes words. The cell row
// registers the per-byte compares, and the output stage ANDs them and
// registers the result word.
// Reset empties the pattern and restarts the text; no setup pass is needed.
// When m_axis stalls, one word waits in the output register and one more in
// the compare stage; after that s_axis_tready drops until m_axis takes a word.
module rolling_hash_string_matcher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] byte_value
    input  logic [rhsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: [1:0] action
    input  logic [rhsm_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [0] match, [32:1] match_start, [33] pattern_overflow, [39:34] zero
    output logic [rhsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int N = rhsm_pkg::MAX_PATTERN;

    rhsm_pkg::action_t                   action;
    logic [rhsm_pkg::BYTE_W-1:0]         byte_value;
    logic                                accept;
    logic                                can_append;
    logic                                out_ready;

    logic [rhsm_pkg::LEN_W-1:0]          len_reg;
    logic [rhsm_pkg::LEN_W-1:0]          len_next;
    logic [rhsm_pkg::COUNT_W-1:0]        count_reg;
    logic [rhsm_pkg::COUNT_W-1:0]        count_next;
    logic [rhsm_pkg::COUNT_W-1:0]        count_inc;

    logic                                a_valid_reg;
    rhsm_pkg::stage_info_t               a_info_reg;
    rhsm_pkg::stage_info_t               a_info_next;

    rhsm_pkg::cell_ctrl_t                ctrl;

    logic [rhsm_pkg::BYTE_W-1:0]         pat_q  [N];
    logic [rhsm_pkg::BYTE_W-1:0]         win_q  [N];
    logic [N-1:0]                        used_q;
    logic [N-1:0]                        eq_q;

    assign action     = rhsm_pkg::action_t'(s_axis_tuser);
    assign byte_value = s_axis_tdata[rhsm_pkg::BYTE_W-1:0];

    // The compare stage moves on whenever the output stage can take its word.
    assign s_axis_tready = !a_valid_reg || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign can_append = (len_reg < rhsm_pkg::LEN_W'(N));
    assign count_inc  = (count_reg == '1) ? count_reg : (count_reg + 1'b1);

    always_comb
    begin
        len_next    = len_reg;
        count_next  = count_reg;
        ctrl        = '0;
        a_info_next = '0;
        a_info_next.len = len_reg;
        if (accept)
        begin
            case (action)
                rhsm_pkg::ACT_CLEAR:
                begin
                    len_next   = '0;
                    count_next = '0;
                    ctrl.clear = 1'b1;
                end
                rhsm_pkg::ACT_APPEND:
                begin
                    if (can_append)
                    begin
                        // A longer pattern changes the window, so the text restarts.
                        len_next       = len_reg + 1'b1;
                        count_next     = '0;
                        ctrl.pat_shift = 1'b1;
                    end
                    else
                    begin
                        a_info_next.overflow = 1'b1;
                    end
                end
                rhsm_pkg::ACT_TEXT:
                begin
                    count_next          = count_inc;
                    ctrl.win_shift      = 1'b1;
                    a_info_next.is_text = 1'b1;
                end
                rhsm_pkg::ACT_RESTART:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        a_info_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            count_reg <= count_next;
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_info_reg <= a_info_next;
        end
    end

    // Row of cells: cell 0 takes the incoming byte, each other cell takes
    // its lower neighbor's byte when the row shifts.
    for (genvar j = 0; j < N; j++)
    begin : g_cell
        logic [rhsm_pkg::BYTE_W-1:0] pat_in;
        logic [rhsm_pkg::BYTE_W-1:0] win_in;
        logic                        used_in;

        if (j == 0)
        begin : g_head
            assign pat_in  = byte_value;
            assign win_in  = byte_value;
            assign used_in = 1'b1;
        end
        else
        begin : g_body
            assign pat_in  = pat_q[j-1];
            assign win_in  = win_q[j-1];
            assign used_in = used_q[j-1];
        end

        rhsm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pat_in   (pat_in),
            .win_in   (win_in),
            .used_in  (used_in),
            .pat_out  (pat_q[j]),
            .win_out  (win_q[j]),
            .used_out (used_q[j]),
            .eq_out   (eq_q[j])
        );
    end

    rhsm_match u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (a_valid_reg),
        .in_ready      (out_ready),
        .info          (a_info_reg),
        .eq_bits       (eq_q),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    property p_len_bounded;
        @(posedge clk) disable iff (!rst_n)
        len_reg <= rhsm_pkg::LEN_W'(N);
    endproperty
    a_len_bounded: assert property (p_len_bounded)
        else $error("pattern length beyond capacity");

    property p_used_matches_len;
        @(posedge clk) disable iff (!rst_n)
        $countones(used_q) == int'(len_reg);
    endproperty
    a_used_matches_len: assert property (p_used_matches_len)
        else $error("used cells disagree with pattern length");

    property p_clear_empties;
        @(posedge clk) disable iff (!rst_n)
        (accept && action == rhsm_pkg::ACT_CLEAR) |=> (len_reg == '0 && count_reg == '0);
    endproperty
    a_clear_empties: assert property (p_clear_empties)
        else $error("clear did not empty pattern and text");

    property p_full_append_keeps_len;
        @(posedge clk) disable iff (!rst_n)
        (accept && action == rhsm_pkg::ACT_APPEND && !can_append) |=> $stable(len_reg);
    endproperty
    a_full_append_keeps_len: assert property (p_full_append_keeps_len)
        else $error("dropped pattern byte changed the pattern");

endmodule
